// ----- rtl/pef_pkg.sv -----
// Shared types and constants for the peak envelope follower.
// Holds the register map, reset values and the controller/datapath
// command and status bundles. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pef_pkg;

    // Fixed widths of the ramp machinery
    localparam int RAMP_W = 10;
    localparam int ADDR_W = 4;
    localparam int STEP_W = 32;
    localparam int QUO_W  = 31;
    localparam int CNT_W  = 5;

    // Register indexes (byte address 4*index)
    localparam logic [1:0] REG_STEREO  = 2'd0;
    localparam logic [1:0] REG_ATTACK  = 2'd1;
    localparam logic [1:0] REG_RELEASE = 2'd2;
    localparam logic [1:0] REG_RAMP    = 2'd3;

    // Register reset values
    localparam logic              STEREO_RST = 1'b1;
    localparam logic [RAMP_W-1:0] RAMP_RST   = 10'd240;

    // Lane selectors for the two coefficient ramps
    localparam logic LANE_ATTACK  = 1'b0;
    localparam logic LANE_RELEASE = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic check;
        logic div_start;
        logic start_sel;
        logic div_write;
        logic write_sel;
        logic mul;
        logic upd;
        logic env;
        logic fin;
    } pef_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic chg_a;
        logic chg_r;
        logic ramp_zero;
        logic div_done;
        logic out_free;
    } pef_stat_t;

endpackage

`default_nettype wire

// ----- rtl/peak_envelope_follower_unit.sv -----
// Peak envelope follower: a frame is not accepted until the previous frame has
// been sequenced through to its registered result word.
// A coefficient target change with nonzero ramp length adds a step division for each
// changed coefficient, run on the bit-serial step divider (31 quotient bits).
// A finished word waits in the output register while the next frame is taken.
// Asynchronous active-low reset restores the register reset values and clears the ramps and the envelope.
`timescale 1ns / 1ps
`default_nettype none

module peak_envelope_follower_unit
#(
    parameter int SAMPLE_BITS = 24,
    parameter int COEFF_BITS  = 16,
    localparam int IN_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // Input frame stream
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [IN_W-1:0]            s_tdata,  // left_sample, right_sample
    input  wire logic                       s_tlast,  // block_end
    // Envelope stream
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [OUT_W-1:0]                m_tdata,  // envelope
    output logic                            m_tlast,  // block_end_out
    // Register port
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [pef_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import pef_pkg::*;

    logic                  stereo_reg;
    logic [COEFF_BITS-1:0] attack_reg;
    logic [COEFF_BITS-1:0] release_reg;
    logic [RAMP_W-1:0]     ramp_reg;
    logic                  wr_en;
    logic [1:0]            reg_idx;
    logic [SAMPLE_BITS-1:0] env_word;
    pef_cmd_t              cmd;
    pef_stat_t             stat;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stereo_reg  <= STEREO_RST;
            attack_reg  <= '0;
            release_reg <= '0;
            ramp_reg    <= RAMP_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_STEREO:  stereo_reg  <= pwdata[0];
                REG_ATTACK:  attack_reg  <= pwdata[COEFF_BITS-1:0];
                REG_RELEASE: release_reg <= pwdata[COEFF_BITS-1:0];
                REG_RAMP:    ramp_reg    <= pwdata[RAMP_W-1:0];
                default:     stereo_reg  <= stereo_reg;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        case (reg_idx)
            REG_STEREO:  prdata = 32'(stereo_reg);
            REG_ATTACK:  prdata = 32'(attack_reg);
            REG_RELEASE: prdata = 32'(release_reg);
            REG_RAMP:    prdata = 32'(ramp_reg);
            default:     prdata = '0;
        endcase
    end

    pef_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pef_datapath
    #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEFF_BITS  (COEFF_BITS)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .left_sample   (s_tdata[SAMPLE_BITS-1:0]),
        .right_sample  (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .block_end     (s_tlast),
        .stereo_mode   (stereo_reg),
        .attack_coeff  (attack_reg),
        .release_coeff (release_reg),
        .ramp_steps    (ramp_reg),
        .cfg_snap      (wr_en && (reg_idx == REG_RAMP)),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .envelope      (env_word),
        .block_end_out (m_tlast)
    );

    assign m_tdata = OUT_W'(env_word);

endmodule

`default_nettype wire

// ----- rtl/pef_div.sv -----
// Restoring divider for the coefficient ramp step, one quotient bit per cycle.
// Divides a 31-bit magnitude by the 10-bit ramp length. Depends on pef_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pef_div
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [pef_pkg::QUO_W-1:0]  dividend,
    input  wire logic [pef_pkg::RAMP_W-1:0] divisor,
    output logic                            done,
    output logic [pef_pkg::QUO_W-1:0]       quotient
);
    import pef_pkg::*;

    localparam logic [CNT_W-1:0] LAST = CNT_W'(QUO_W - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [QUO_W-1:0] quo_reg;
    logic [RAMP_W-1:0] rem_reg;
    logic [RAMP_W:0]  rem_sh;
    logic [RAMP_W:0]  rem_diff;
    logic             fits;

    // One restoring step: shift in the next dividend bit and try to subtract.
    assign rem_sh   = {rem_reg, quo_reg[QUO_W-1]};
    assign fits     = (rem_sh >= {1'b0, divisor});
    assign rem_diff = rem_sh - {1'b0, divisor};

    // Iteration control
    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Quotient bits shift in where the dividend bits shift out.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
            rem_reg <= fits ? rem_diff[RAMP_W-1:0] : rem_sh[RAMP_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- rtl/pef_datapath.sv -----
// Datapath of the peak envelope follower: input capture, peak detection,
// the two coefficient ramps, the smoothing multiply and the output word.
// Depends on pef_pkg and pef_div.
`timescale 1ns / 1ps
`default_nettype none

module pef_datapath
#(
    parameter int SAMPLE_BITS = 24,
    parameter int COEFF_BITS  = 16
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire pef_pkg::pef_cmd_t          cmd,
    output pef_pkg::pef_stat_t              stat,
    input  wire logic [SAMPLE_BITS-1:0]     left_sample,
    input  wire logic [SAMPLE_BITS-1:0]     right_sample,
    input  wire logic                       block_end,
    input  wire logic                       stereo_mode,
    input  wire logic [COEFF_BITS-1:0]      attack_coeff,
    input  wire logic [COEFF_BITS-1:0]      release_coeff,
    input  wire logic [pef_pkg::RAMP_W-1:0] ramp_steps,
    input  wire logic                       cfg_snap,
    input  wire logic                       out_ready,
    output logic                            out_valid,
    output logic [SAMPLE_BITS-1:0]          envelope,
    output logic                            block_end_out
);
    import pef_pkg::*;

    localparam int SB      = SAMPLE_BITS;
    localparam int C       = COEFF_BITS;
    localparam int S       = 31 - COEFF_BITS;
    localparam int PROD_W  = STEP_W + RAMP_W + 1;
    localparam int V_W     = PROD_W + 2;
    localparam int EP_W    = C + SB + 2;
    localparam int ES_W    = EP_W + 1;
    localparam logic [PROD_W:0]  R_HALF = (PROD_W + 1)'(1) << (S - 1);
    localparam logic [ES_W-1:0]  E_HALF = ES_W'(1) << (C - 1);
    localparam logic [V_W-1:0]   V_MAX  = V_W'({C{1'b1}});

    // Two's complement magnitude; the most negative code gives 2^(SB-1).
    function automatic logic [SB-1:0] mag_of(input logic [SB-1:0] v);
        logic [SB-1:0] r;
        r = v[SB-1] ? (~v + 1'b1) : v;
        return r;
    endfunction

    // Captured frame and peak
    logic [SB-1:0] left_reg;
    logic [SB-1:0] right_reg;
    logic          last_reg;
    logic [SB-1:0] peak_reg;
    logic [SB-1:0] mag_l;
    logic [SB-1:0] mag_r;

    // Ramp lanes: index 0 is attack, index 1 is release
    logic [C-1:0]               tgt       [2];
    logic [C-1:0]               cur_reg   [2];
    logic [C-1:0]               seen_reg  [2];
    logic signed [STEP_W-1:0]   step_reg  [2];
    logic [RAMP_W-1:0]          cntd_reg  [2];
    logic [1:0]                 adv_reg;
    logic signed [PROD_W-1:0]   rprod_reg [2];
    logic [1:0]                 chg;
    logic [RAMP_W-1:0]          cnt_dec   [2];
    logic [PROD_W-1:0]          pmag      [2];
    logic [PROD_W:0]            prnd      [2];
    logic [V_W-1:0]             v_seen    [2];
    logic [V_W-1:0]             v_off     [2];
    logic signed [V_W-1:0]      v_val     [2];
    logic [C-1:0]               clamped   [2];

    // Step division
    logic                       div_neg_reg;
    logic signed [C:0]          diff;
    logic [C-1:0]               diff_mag;
    logic [QUO_W-1:0]           dividend;
    logic [QUO_W-1:0]           quotient;
    logic                       div_done;
    logic signed [STEP_W-1:0]   qstep;

    // Envelope
    logic [SB-1:0]              env_reg;
    logic [C-1:0]               a_sel;
    logic signed [EP_W-1:0]     eprod_reg;
    logic [ES_W-1:0]            env_sum;

    // Output word
    logic                       out_valid_reg, out_valid_next;
    logic [SB-1:0]              out_env_reg;
    logic                       out_last_reg;

    assign tgt[0] = attack_coeff;
    assign tgt[1] = release_coeff;

    assign mag_l = mag_of(left_reg);
    assign mag_r = mag_of(right_reg);

    // Per-lane ramp arithmetic: countdown, rounded offset and clamp
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            chg[i]     = (tgt[i] != seen_reg[i]);
            cnt_dec[i] = cntd_reg[i] - 1'b1;
            pmag[i]    = rprod_reg[i][PROD_W-1] ? PROD_W'(-rprod_reg[i])
                                                : PROD_W'(rprod_reg[i]);
            prnd[i]    = {1'b0, pmag[i]} + R_HALF;
            v_seen[i]  = V_W'(seen_reg[i]);
            v_off[i]   = V_W'(prnd[i][PROD_W:S]);
            v_val[i]   = rprod_reg[i][PROD_W-1] ? $signed(v_seen[i] + v_off[i])
                                                : $signed(v_seen[i] - v_off[i]);
            if (v_val[i][V_W-1])
                clamped[i] = '0;
            else if ($unsigned(v_val[i]) > V_MAX)
                clamped[i] = {C{1'b1}};
            else
                clamped[i] = v_val[i][C-1:0];
        end
    end

    // Divider operands for the lane that starts a ramp
    always_comb
    begin
        if (cmd.start_sel == LANE_RELEASE)
            diff = $signed({1'b0, tgt[1]}) - $signed({1'b0, cur_reg[1]});
        else
            diff = $signed({1'b0, tgt[0]}) - $signed({1'b0, cur_reg[0]});
        diff_mag = diff[C] ? C'(-diff) : diff[C-1:0];
    end

    assign dividend = {diff_mag, {S{1'b0}}};
    assign qstep    = div_neg_reg ? -$signed({1'b0, quotient})
                                  : $signed({1'b0, quotient});

    pef_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (ramp_steps),
        .done     (div_done),
        .quotient (quotient)
    );

    // Smoothing: env' = (peak*2^C + a*(env - peak) + half) >> C
    assign a_sel   = (peak_reg > env_reg) ? cur_reg[0] : cur_reg[1];
    assign env_sum = {3'b000, peak_reg, {C{1'b0}}} + {eprod_reg[EP_W-1], eprod_reg} + E_HALF;

    // Ramp and envelope state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                cur_reg[i]  <= '0;
                seen_reg[i] <= '0;
                step_reg[i] <= '0;
                cntd_reg[i] <= '0;
            end
            adv_reg <= '0;
            env_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < 2; i++)
            begin
                if (cfg_snap)
                begin
                    cur_reg[i]  <= seen_reg[i];
                    cntd_reg[i] <= '0;
                    step_reg[i] <= '0;
                end
                else if (cmd.check && chg[i])
                begin
                    seen_reg[i] <= tgt[i];
                    if (ramp_steps == '0)
                    begin
                        cur_reg[i]  <= tgt[i];
                        cntd_reg[i] <= '0;
                        step_reg[i] <= '0;
                    end
                end
                else if (cmd.div_write && (cmd.write_sel == 1'(i)))
                begin
                    step_reg[i] <= qstep;
                    cntd_reg[i] <= ramp_steps;
                end
                else if (cmd.mul)
                begin
                    adv_reg[i] <= (cntd_reg[i] != '0);
                    if (cntd_reg[i] != '0)
                        cntd_reg[i] <= cnt_dec[i];
                end
                else if (cmd.upd && adv_reg[i])
                begin
                    cur_reg[i] <= (cntd_reg[i] == '0) ? seen_reg[i] : clamped[i];
                end
            end
            if (cmd.fin)
                env_reg <= env_sum[C+SB-1:C];
        end
    end

    // Frame capture, products and divider sign
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            left_reg  <= left_sample;
            right_reg <= right_sample;
            last_reg  <= block_end;
        end
        if (cmd.check)
            peak_reg <= (stereo_mode && (mag_r > mag_l)) ? mag_r : mag_l;
        if (cmd.div_start)
            div_neg_reg <= diff[C];
        for (int i = 0; i < 2; i++)
        begin
            if (cmd.mul)
                rprod_reg[i] <= step_reg[i] * $signed({1'b0, cnt_dec[i]});
        end
        if (cmd.env)
            eprod_reg <= $signed({1'b0, a_sel})
                         * ($signed({1'b0, env_reg}) - $signed({1'b0, peak_reg}));
        if (cmd.fin)
        begin
            out_env_reg  <= env_sum[C+SB-1:C];
            out_last_reg <= last_reg;
        end
    end

    // Output word holds until taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.fin)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign stat.chg_a     = chg[0];
    assign stat.chg_r     = chg[1];
    assign stat.ramp_zero = (ramp_steps == '0);
    assign stat.div_done  = div_done;
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign envelope      = out_env_reg;
    assign block_end_out = out_last_reg;

endmodule

`default_nettype wire

// ----- rtl/pef_ctrl.sv -----
// Controller of the peak envelope follower: sequences one frame through
// capture, ramp check, optional step divisions, ramp update and smoothing.
// Depends on pef_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pef_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire pef_pkg::pef_stat_t stat,
    output pef_pkg::pef_cmd_t       cmd
);
    import pef_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_CHK  = 8'b0000_0010,
        S_DIVA = 8'b0000_0100,
        S_DIVR = 8'b0000_1000,
        S_MUL  = 8'b0001_0000,
        S_UPD  = 8'b0010_0000,
        S_ENV  = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   pend_r_reg, pend_r_next;

    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        pend_r_next = pend_r_reg;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHK;
                end
            end
            S_CHK:
            begin
                cmd.check   = 1'b1;
                pend_r_next = stat.chg_r && !stat.ramp_zero;
                if (stat.chg_a && !stat.ramp_zero)
                begin
                    cmd.div_start = 1'b1;
                    cmd.start_sel = LANE_ATTACK;
                    state_next    = S_DIVA;
                end
                else if (stat.chg_r && !stat.ramp_zero)
                begin
                    cmd.div_start = 1'b1;
                    cmd.start_sel = LANE_RELEASE;
                    pend_r_next   = 1'b0;
                    state_next    = S_DIVR;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_DIVA:
            begin
                if (stat.div_done)
                begin
                    cmd.div_write = 1'b1;
                    cmd.write_sel = LANE_ATTACK;
                    if (pend_r_reg)
                    begin
                        cmd.div_start = 1'b1;
                        cmd.start_sel = LANE_RELEASE;
                        pend_r_next   = 1'b0;
                        state_next    = S_DIVR;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_DIVR:
            begin
                if (stat.div_done)
                begin
                    cmd.div_write = 1'b1;
                    cmd.write_sel = LANE_RELEASE;
                    state_next    = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = S_ENV;
            end
            S_ENV:
            begin
                cmd.env    = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pend_r_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pend_r_reg <= pend_r_next;
        end
    end

endmodule

`default_nettype wire
